@@ hdl/msp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

   localparam int POOL_SLOTS  = 64;
   localparam int STACK_COUNT = 4;
   localparam int DATA_W      = 32;
   localparam int SLOT_W      = $clog2(POOL_SLOTS);
   localparam int PTR_W       = $clog2(POOL_SLOTS + 1);
   localparam int SEL_W       = $clog2(STACK_COUNT);
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_USER_W  = 4;

   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SLOTS);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 2'd0,
      KIND_POP  = 2'd1,
      KIND_PEEK = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

@@ hdl/multi_stack_shared_pool_top.sv @@
// an accepted request has its link and value memory reads registered, then is committed in the
// exec state once the response register is free, which loads the response beat; a new request
// is taken only in the idle state, after the write back of the previous one, so none overlap
// reset: every stack empty, free list through all slots in order, taking effect at once
// with no clearing pass; unwritten link entries read their reset value via valid bits
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_pool_top
   import msp_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [DATA_W-1:0]      req_tdata,   // push_value
   input  wire  [REQ_USER_W-1:0]  req_tuser,   // kind[1:0], stack_select[3:2]
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // read_value
   output logic [RSP_USER_W-1:0]  rsp_tuser    // status[1:0], selected_empty[2], pool_full[3]
);

   state_type state_ff, state_in;

   logic [DATA_W-1:0] value_mem [POOL_SLOTS];
   logic [PTR_W-1:0]  link_mem  [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] link_vld_ff;

   logic [PTR_W-1:0]  stack_heads_ff [STACK_COUNT];
   logic [PTR_W-1:0]  free_head_ff;

   kind_type          kind_ff;
   logic [SEL_W-1:0]  sel_ff;
   logic [DATA_W-1:0] push_value_ff;
   logic [PTR_W-1:0]  slot_ff;
   logic [PTR_W-1:0]  link_rd_ff;
   logic              link_vld_rd_ff;
   logic [DATA_W-1:0] value_rd_ff;

   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic              accept;
   logic              commit;
   kind_type          req_kind;
   logic [SEL_W-1:0]  req_sel;
   logic [PTR_W-1:0]  lookup_ptr;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;

   logic [PTR_W-1:0]  cur_head;
   logic              slot_ok;
   logic [PTR_W-1:0]  link_val;
   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  free_head_in;
   logic              link_wr;
   logic [PTR_W-1:0]  link_wdata;
   logic              value_wr;
   logic [DATA_W-1:0] read_value;
   status_type        status;
   logic              sel_empty;
   logic              pool_full;

   // request decode and lookup address
   always_comb begin
      req_kind   = kind_type'(req_tuser[KIND_W-1:0]);
      req_sel    = req_tuser[KIND_W +: SEL_W];
      lookup_ptr = (req_kind == KIND_PUSH) ? free_head_ff : stack_heads_ff[req_sel];
      rd_addr    = lookup_ptr[SLOT_W-1:0];
      wr_addr    = slot_ff[SLOT_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: commit = !rsp_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // modify step
   always_comb begin
      cur_head     = stack_heads_ff[sel_ff];
      slot_ok      = slot_ff < NULL_PTR;
      link_val     = link_vld_rd_ff ? link_rd_ff : PTR_W'(wr_addr) + PTR_W'(1);
      head_in      = cur_head;
      free_head_in = free_head_ff;
      link_wr      = 1'b0;
      link_wdata   = cur_head;
      value_wr     = 1'b0;
      read_value   = '0;
      status       = STATUS_OK;
      case (kind_ff)
         KIND_PUSH: begin
            if (slot_ok) begin
               free_head_in = link_val;
               head_in      = slot_ff;
               link_wr      = 1'b1;
               link_wdata   = cur_head;
               value_wr     = 1'b1;
            end else begin
               status = STATUS_OVERFLOW;
            end
         end
         KIND_POP: begin
            if (slot_ok) begin
               read_value   = value_rd_ff;
               head_in      = link_val;
               free_head_in = slot_ff;
               link_wr      = 1'b1;
               link_wdata   = free_head_ff;
            end else begin
               status = STATUS_UNDERFLOW;
            end
         end
         KIND_PEEK: begin
            if (slot_ok) begin
               read_value = value_rd_ff;
            end else begin
               status = STATUS_UNDERFLOW;
            end
         end
         default: status = STATUS_OK;
      endcase
      sel_empty = !(head_in < NULL_PTR);
      pool_full = !(free_head_in < NULL_PTR);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         link_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STACK_COUNT; i++) begin
            stack_heads_ff[i] <= NULL_PTR;
         end
      end else begin
         state_ff <= state_in;
         if (commit) begin
            free_head_ff           <= free_head_in;
            stack_heads_ff[sel_ff] <= head_in;
            if (link_wr) link_vld_ff[wr_addr] <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and registered memory reads
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff        <= req_kind;
         sel_ff         <= req_sel;
         push_value_ff  <= req_tdata;
         slot_ff        <= lookup_ptr;
         link_rd_ff     <= link_mem[rd_addr];
         link_vld_rd_ff <= link_vld_ff[rd_addr];
         value_rd_ff    <= value_mem[rd_addr];
      end
   end

   // memory write back
   always_ff @(posedge clock) begin
      if (commit && link_wr) link_mem[wr_addr] <= link_wdata;
      if (commit && value_wr) value_mem[wr_addr] <= push_value_ff;
   end

   // response register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= read_value;
         rsp_user_ff <= {pool_full, sel_empty, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

@@ dv/tb_multi_stack_shared_pool_top.sv @@
`timescale 1ns / 1ps

module tb_multi_stack_shared_pool_top;
   import msp_pkg::*;

   localparam int ITEM_TARGET = 1850;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      kind_type                kind;
      logic [SEL_W-1:0]        sel;
      logic [DATA_W-1:0]       value;
      bit                      hold_for_drain;
   } stack_op_type;

   typedef struct {
      logic [DATA_W-1:0]       read_value;
      status_type              status;
      bit                      selected_empty;
      bit                      pool_full;
   } stack_reply_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;     // push_value
   logic [REQ_USER_W-1:0]  req_tuser = '0;     // kind[1:0], stack_select[3:2]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;          // read_value
   logic [RSP_USER_W-1:0]  rsp_tuser;          // status[1:0], selected_empty[2], pool_full[3]

   multi_stack_shared_pool_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow copy of the pool
   logic [DATA_W-1:0] pool_value [POOL_SLOTS];
   logic [PTR_W-1:0]  pool_next  [POOL_SLOTS];
   logic [PTR_W-1:0]  top_slot   [STACK_COUNT];
   logic [PTR_W-1:0]  free_slot;

   stack_op_type     op_queue[$];
   stack_reply_type  awaited_replies[$];
   stack_op_type     cur_op;

   int errors = 0;
   int replies_checked = 0;
   int push_count = 0, pop_count = 0, peek_count = 0;
   int overflow_count = 0, underflow_count = 0;
   int burst_left = 0, gap_left = 0;
   int idle_cycles = 0;
   int ready_mode = 0;
   int cycle_count = 0;
   logic [15:0] ready_pattern = 16'hffff;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void clear_pool();
      for (int i = 0; i < POOL_SLOTS; i++) begin
         pool_value[i] = '0;
         pool_next[i]  = (i + 1 < POOL_SLOTS) ? PTR_W'(i + 1) : NULL_PTR;
      end
      for (int s = 0; s < STACK_COUNT; s++) top_slot[s] = NULL_PTR;
      free_slot = '0;
   endfunction

   function automatic stack_reply_type stack_pool_apply(stack_op_type op);
      stack_reply_type r;
      logic [PTR_W-1:0] slot;
      r.read_value = '0;
      r.status     = STATUS_OK;
      case (op.kind)
         KIND_PUSH: begin
            slot = free_slot;
            if (slot >= POOL_SLOTS) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               free_slot = pool_next[slot[SLOT_W-1:0]];
               pool_next[slot[SLOT_W-1:0]] = top_slot[op.sel];
               top_slot[op.sel] = slot;
               pool_value[slot[SLOT_W-1:0]] = op.value;
            end
         end
         KIND_POP, KIND_PEEK: begin
            slot = top_slot[op.sel];
            if (slot >= POOL_SLOTS) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = pool_value[slot[SLOT_W-1:0]];
               if (op.kind == KIND_POP) begin
                  top_slot[op.sel] = pool_next[slot[SLOT_W-1:0]];
                  pool_next[slot[SLOT_W-1:0]] = free_slot;
                  free_slot = slot;
               end
            end
         end
         default: ;
      endcase
      r.selected_empty = (top_slot[op.sel] >= POOL_SLOTS);
      r.pool_full      = (free_slot >= POOL_SLOTS);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_op(kind_type kind, int sel, logic [DATA_W-1:0] value,
                                  bit hold);
      stack_op_type op;
      op.kind           = kind;
      op.sel            = SEL_W'(sel);
      op.value          = value;
      op.hold_for_drain = hold;
      op_queue.push_back(op);
   endfunction

   // stimulus
   initial begin
      int total;
      int seg_len;
      int push_pct;
      bit focus;
      int focus_sel;
      int sel;
      kind_type k;

      clear_pool();

      add_op(KIND_PEEK, 0, 32'h1234_5678, 0);
      add_op(KIND_POP,  3, 32'h0, 0);
      add_op(KIND_PUSH, 0, 32'h7fff_ffff, 0);
      add_op(KIND_PUSH, 0, 32'h8000_0000, 0);
      add_op(KIND_PUSH, 1, 32'h0000_0000, 0);
      add_op(KIND_PUSH, 2, 32'hffff_ffff, 0);
      add_op(KIND_PUSH, 3, 32'h5555_5555, 0);
      add_op(KIND_PUSH, 3, 32'haaaa_aaaa, 0);
      add_op(KIND_PEEK, 0, 32'hffff_ffff, 0);
      add_op(KIND_POP,  0, 32'h0, 0);
      add_op(KIND_POP,  0, 32'h0, 0);
      add_op(KIND_POP,  0, 32'h0, 0);
      add_op(KIND_PEEK, 3, 32'h0, 0);
      add_op(KIND_POP,  3, 32'h0, 0);
      add_op(KIND_POP,  3, 32'h0, 0);
      add_op(KIND_PEEK, 1, 32'h0, 0);
      add_op(KIND_POP,  1, 32'h0, 0);
      add_op(KIND_POP,  2, 32'h0, 0);
      add_op(KIND_PEEK, 2, 32'h0, 0);
      add_op(KIND_POP,  1, 32'h0, 0);

      total = 0;
      while (total < ITEM_TARGET) begin
         seg_len = $urandom_range(20, 120);
         case ($urandom_range(0, 5))
            0: push_pct = 10;
            1: push_pct = 35;
            2: push_pct = 50;
            3: push_pct = 65;
            4: push_pct = 85;
            default: push_pct = 100;
         endcase
         focus     = ($urandom_range(0, 2) == 0);
         focus_sel = $urandom_range(0, STACK_COUNT - 1);
         for (int i = 0; i < seg_len; i++) begin
            sel = focus ? focus_sel : $urandom_range(0, STACK_COUNT - 1);
            if ($urandom_range(1, 100) <= push_pct) k = KIND_PUSH;
            else if ($urandom_range(0, 9) < 3) k = KIND_PEEK;
            else k = KIND_POP;
            add_op(k, sel, pick_value(),
                   (total == 0) || (i == 0 && $urandom_range(0, 3) == 0));
            total++;
         end
      end
   end

   // driver
   always @(posedge clock) begin
      stack_reply_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         burst_left <= $urandom_range(1, 48);
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            r = stack_pool_apply(cur_op);
            awaited_replies.push_back(r);
            case (cur_op.kind)
               KIND_PUSH: push_count++;
               KIND_POP:  pop_count++;
               default:   peek_count++;
            endcase
            if (r.status == STATUS_OVERFLOW) overflow_count++;
            if (r.status == STATUS_UNDERFLOW) underflow_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (op_queue.size() != 0 &&
                         !(op_queue[0].hold_for_drain && awaited_replies.size() != 0)) begin
               cur_op = op_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= cur_op.value;
               req_tuser  <= {cur_op.sel, cur_op.kind};
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count % 64 == 0) begin
            ready_mode    = $urandom_range(0, 3);
            ready_pattern = 16'($urandom);
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ready_pattern[cycle_count[3:0]];
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      stack_reply_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            $error("unexpected response beat: read_value %h tuser %h", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp = awaited_replies.pop_front();
            replies_checked++;
            if (rsp_tdata !== exp.read_value) begin
               $error("read_value expected %h actual %h", exp.read_value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[1:0] !== exp.status) begin
               $error("status expected %0d actual %0d", exp.status, rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tuser[2] !== exp.selected_empty) begin
               $error("selected_empty expected %0b actual %0b",
                      exp.selected_empty, rsp_tuser[2]);
               errors++;
            end
            if (rsp_tuser[3] !== exp.pool_full) begin
               $error("pool_full expected %0b actual %0b", exp.pool_full, rsp_tuser[3]);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (op_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         $error("%0d expected responses never arrived", awaited_replies.size());
         errors++;
      end
      $display("ops: %0d push, %0d pop, %0d peek; %0d overflow, %0d underflow",
               push_count, pop_count, peek_count, overflow_count, underflow_count);
      $display("responses checked: %0d, errors: %0d", replies_checked, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/msp_pkg.sv
hdl/multi_stack_shared_pool_top.sv
dv/tb_multi_stack_shared_pool_top.sv
